FILE: rtl/tpre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpre_pkg
// Shared types and constants of the tape pulse record encoder.
// ----------------------------------------------------------------------------
package tpre_pkg;

    // parameter defaults
    localparam int DEF_LONG_BITS  = 39;
    localparam int DEF_COUNT_BITS = 32;

    // field widths
    localparam int DELTA_W   = 39;
    localparam int TIMER_W   = 8;
    localparam int SECS_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int CNT_OUT_W = 32;
    localparam int TOTAL_W   = 64;

    // datapath widths
    localparam int ACC_W    = 48;   // holds delta * timer + precision / 2
    localparam int MPLIER_W = 20;   // holds one million
    localparam int STEP_W   = 6;    // counts up to ACC_W serial steps
    localparam int LIM_W    = 16;   // short-signal limits and the minimum start delay
    localparam int SREG_W   = 40;   // five record bytes
    localparam int BCNT_W   = 3;

    localparam logic [MPLIER_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [ACC_W-1:0]    SHORT_LIMIT  = 48'h8000;
    localparam logic [LIM_W-1:0]    WARN_US      = 16'd40;
    localparam logic [LIM_W-1:0]    ERR_US       = 16'd25;
    localparam logic [LIM_W-1:0]    MIN_START_US = 16'd100;
    localparam logic [BCNT_W-1:0]   SHORT_BYTES  = 3'd2;
    localparam logic [BCNT_W-1:0]   LONG_BYTES   = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MHZ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_SECS   = 3'd5;

    // stop delay modes
    localparam logic [1:0] STOP_SECONDS = 2'd1;
    localparam logic [1:0] STOP_MAX     = 2'd2;

    // input operations
    localparam logic OP_END = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_CHECK,
        ST_LOAD,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/tape_pulse_record_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tape_pulse_record_encoder
// Rescales capture deltas to timer ticks with a bit-serial shift-add
// multiplier and restoring divider, checks short signals, and streams
// 2- or 5-byte tape records with running warning, error and tick totals.
// ----------------------------------------------------------------------------
// Flow: 8 multiply steps (28 for second-based delays), then 48 divide
// steps when the precision needs rescaling, then the saturate, check and
// load states, then the record bytes (2 or 5, 1 for status), one per
// output handshake. One item at a time: no new input until the last byte
// is taken. Reset: registers at their defaults, counters and total
// cleared, next delta treated as the first of a stream.
module tape_pulse_record_encoder #(
    parameter int LONG_BITS  = tpre_pkg::DEF_LONG_BITS,
    parameter int COUNT_BITS = tpre_pkg::DEF_COUNT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tpre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpre_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [tpre_pkg::DELTA_W-1:0]      delta,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        tape_byte,
    output logic                              byte_valid,
    output logic                              last,
    output logic [tpre_pkg::CNT_OUT_W-1:0]    warning_count,
    output logic [tpre_pkg::CNT_OUT_W-1:0]    error_count,
    output logic [tpre_pkg::TOTAL_W-1:0]      total_ticks
);

    localparam int ACC_W    = tpre_pkg::ACC_W;
    localparam int MPLIER_W = tpre_pkg::MPLIER_W;
    localparam int STEP_W   = tpre_pkg::STEP_W;
    localparam int LIM_W    = tpre_pkg::LIM_W;
    localparam int SREG_W   = tpre_pkg::SREG_W;
    localparam int BCNT_W   = tpre_pkg::BCNT_W;
    localparam int TIMER_W  = tpre_pkg::TIMER_W;
    localparam int SECS_W   = tpre_pkg::SECS_W;
    localparam int DELTA_W  = tpre_pkg::DELTA_W;
    localparam int TOTAL_W  = tpre_pkg::TOTAL_W;

    localparam logic [ACC_W-1:0]      LONG_MAX  = ACC_W'((64'd1 << LONG_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [STEP_W-1:0]     TIMER_STEPS = STEP_W'(TIMER_W);
    localparam logic [STEP_W-1:0]     SEC_STEPS   = STEP_W'(MPLIER_W);
    localparam logic [STEP_W-1:0]     DIV_STEPS   = STEP_W'(ACC_W);

    tpre_pkg::state_t state_reg, state_next, dispatch_state;

    logic [TIMER_W-1:0]    timer_reg, prec_reg;
    logic                  start_on_reg;
    logic [SECS_W-1:0]     start_secs_reg, stop_secs_reg;
    logic [1:0]            stop_mode_reg;

    logic                  first_reg, first_next;
    logic [COUNT_BITS-1:0] warn_reg, warn_next, err_reg, err_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [ACC_W-1:0]      acc_reg, acc_next, mcand_reg, mcand_next;
    logic [MPLIER_W-1:0]   mplier_reg, mplier_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [TIMER_W-1:0]    rem_reg, rem_next;
    logic                  chain_reg, chain_next, div_reg, div_next;
    logic                  check_reg, check_next, status_reg, status_next;
    logic [SREG_W-1:0]     sreg_reg, sreg_next;
    logic [BCNT_W-1:0]     bytes_reg, bytes_next;

    logic                  in_acc, out_acc;
    logic [TIMER_W-1:0]    prec_eff;
    logic [LIM_W-1:0]      warn_lim, err_lim, min_start;
    logic [ACC_W-1:0]      acc_sum;
    logic [TIMER_W:0]      trial;
    logic                  q_bit;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign prec_eff = (prec_reg == '0) ? TIMER_W'(1) : prec_reg;
    assign warn_lim  = LIM_W'(timer_reg) * tpre_pkg::WARN_US;
    assign err_lim   = LIM_W'(timer_reg) * tpre_pkg::ERR_US;
    assign min_start = LIM_W'(timer_reg) * tpre_pkg::MIN_START_US;
    assign acc_sum  = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign trial    = {rem_reg, acc_reg[ACC_W-1]};
    assign q_bit    = (trial >= {1'b0, prec_reg});

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg      <= TIMER_W'(1);
            prec_reg       <= TIMER_W'(1);
            start_on_reg   <= 1'b0;
            start_secs_reg <= '0;
            stop_mode_reg  <= '0;
            stop_secs_reg  <= SECS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpre_pkg::CFG_TIMER_MHZ:  timer_reg      <= cfg_data[TIMER_W-1:0];
                tpre_pkg::CFG_PRECISION:  prec_reg       <= cfg_data[TIMER_W-1:0];
                tpre_pkg::CFG_START_ON:   start_on_reg   <= cfg_data[0];
                tpre_pkg::CFG_START_SECS: start_secs_reg <= cfg_data;
                tpre_pkg::CFG_STOP_MODE:  stop_mode_reg  <= cfg_data[1:0];
                tpre_pkg::CFG_STOP_SECS:  stop_secs_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // where an accepted word goes first
    always_comb
    begin
        dispatch_state = tpre_pkg::ST_SAT;
        if (op == tpre_pkg::OP_END)
        begin
            if (stop_mode_reg == tpre_pkg::STOP_SECONDS && stop_secs_reg != '0)
                dispatch_state = tpre_pkg::ST_MUL;
            else if (stop_mode_reg == tpre_pkg::STOP_MAX)
                dispatch_state = tpre_pkg::ST_SAT;
            else
                dispatch_state = tpre_pkg::ST_EMIT;
        end
        else if (first_reg)
        begin
            if (start_on_reg && start_secs_reg != '0)
                dispatch_state = tpre_pkg::ST_MUL;
        end
        else if (prec_eff != timer_reg || prec_eff == TIMER_W'(1))
        begin
            dispatch_state = tpre_pkg::ST_MUL;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tpre_pkg::ST_IDLE:
                if (in_acc)
                    state_next = dispatch_state;
            tpre_pkg::ST_MUL:
                if (step_reg == STEP_W'(1) && !chain_reg)
                    state_next = div_reg ? tpre_pkg::ST_DIV : tpre_pkg::ST_SAT;
            tpre_pkg::ST_DIV:
                if (step_reg == STEP_W'(1))
                    state_next = tpre_pkg::ST_SAT;
            tpre_pkg::ST_SAT:   state_next = tpre_pkg::ST_CHECK;
            tpre_pkg::ST_CHECK: state_next = tpre_pkg::ST_LOAD;
            tpre_pkg::ST_LOAD:  state_next = tpre_pkg::ST_EMIT;
            tpre_pkg::ST_EMIT:
                if (out_ready && bytes_reg == BCNT_W'(1))
                    state_next = tpre_pkg::ST_IDLE;
            default: state_next = tpre_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            tpre_pkg::ST_IDLE: in_ready  = 1'b1;
            tpre_pkg::ST_EMIT: out_valid = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        first_next  = first_reg;
        warn_next   = warn_reg;
        err_next    = err_reg;
        total_next  = total_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        chain_next  = chain_reg;
        div_next    = div_reg;
        check_next  = check_reg;
        status_next = status_reg;
        sreg_next   = sreg_reg;
        bytes_next  = bytes_reg;
        case (state_reg)
            tpre_pkg::ST_IDLE:
                if (in_acc)
                begin
                    status_next = 1'b0;
                    chain_next  = 1'b0;
                    div_next    = 1'b0;
                    check_next  = 1'b1;
                    mplier_next = MPLIER_W'(timer_reg);
                    step_next   = TIMER_STEPS;
                    acc_next    = '0;
                    if (op == tpre_pkg::OP_END)
                    begin
                        first_next = 1'b1;
                        check_next = 1'b0;
                        mcand_next = ACC_W'(stop_secs_reg);
                        chain_next = 1'b1;
                        if (stop_mode_reg == tpre_pkg::STOP_MAX)
                            acc_next = LONG_MAX;
                        bytes_next  = BCNT_W'(1);
                        status_next = !(stop_mode_reg == tpre_pkg::STOP_MAX ||
                                        (stop_mode_reg == tpre_pkg::STOP_SECONDS &&
                                         stop_secs_reg != '0));
                    end
                    else if (first_reg)
                    begin
                        first_next = 1'b0;
                        mcand_next = ACC_W'(start_secs_reg);
                        chain_next = 1'b1;
                        if (!start_on_reg)
                            acc_next = ACC_W'(delta);
                        else if (start_secs_reg == '0)
                            acc_next = ACC_W'(min_start);
                    end
                    else
                    begin
                        mcand_next = ACC_W'(delta);
                        if (prec_eff == TIMER_W'(1))
                            acc_next = '0;
                        else if (prec_eff == timer_reg)
                            acc_next = ACC_W'(delta);
                        else
                        begin
                            // rounding term rides in as the starting sum
                            acc_next = ACC_W'(prec_reg >> 1);
                            div_next = 1'b1;
                        end
                    end
                end
            tpre_pkg::ST_MUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    if (chain_reg)
                    begin
                        // seconds * timer is done, now scale by one million
                        mcand_next  = acc_sum;
                        acc_next    = '0;
                        mplier_next = tpre_pkg::USEC_PER_SEC;
                        step_next   = SEC_STEPS;
                        chain_next  = 1'b0;
                    end
                    else
                    begin
                        rem_next  = '0;
                        step_next = DIV_STEPS;
                    end
                end
            end
            tpre_pkg::ST_DIV:
            begin
                rem_next  = q_bit ? TIMER_W'(trial - {1'b0, prec_reg}) : trial[TIMER_W-1:0];
                acc_next  = {acc_reg[ACC_W-2:0], q_bit};
                step_next = step_reg - STEP_W'(1);
            end
            tpre_pkg::ST_SAT:
                if ((acc_reg >> LONG_BITS) != '0)
                    acc_next = LONG_MAX;
            tpre_pkg::ST_CHECK:
                if (check_reg && acc_reg < ACC_W'(warn_lim))
                begin
                    if (acc_reg < ACC_W'(err_lim))
                    begin
                        err_next = (err_reg == COUNT_MAX) ? err_reg
                                                          : err_reg + COUNT_BITS'(1);
                        acc_next = ACC_W'(err_lim);
                    end
                    else
                    begin
                        warn_next = (warn_reg == COUNT_MAX) ? warn_reg
                                                            : warn_reg + COUNT_BITS'(1);
                    end
                end
            tpre_pkg::ST_LOAD:
            begin
                total_next = total_reg + TOTAL_W'(acc_reg);
                if (acc_reg < tpre_pkg::SHORT_LIMIT)
                begin
                    sreg_next  = {acc_reg[15:0], 24'h0};
                    bytes_next = tpre_pkg::SHORT_BYTES;
                end
                else
                begin
                    sreg_next  = {1'b1, acc_reg[DELTA_W-1:0]};
                    bytes_next = tpre_pkg::LONG_BYTES;
                end
            end
            tpre_pkg::ST_EMIT:
                if (out_ready)
                begin
                    sreg_next  = sreg_reg << 8;
                    bytes_next = bytes_reg - BCNT_W'(1);
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpre_pkg::ST_IDLE;
            first_reg <= 1'b1;
            warn_reg  <= '0;
            err_reg   <= '0;
            total_reg <= '0;
            bytes_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            warn_reg  <= warn_next;
            err_reg   <= err_next;
            total_reg <= total_next;
            bytes_reg <= bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        step_reg   <= step_next;
        rem_reg    <= rem_next;
        chain_reg  <= chain_next;
        div_reg    <= div_next;
        check_reg  <= check_next;
        status_reg <= status_next;
        sreg_reg   <= sreg_next;
    end

    assign tape_byte     = status_reg ? 8'h00 : sreg_reg[SREG_W-1 -: 8];
    assign byte_valid    = !status_reg;
    assign last          = (bytes_reg == BCNT_W'(1));
    assign warning_count = tpre_pkg::CNT_OUT_W'(warn_reg);
    assign error_count   = tpre_pkg::CNT_OUT_W'(err_reg);
    assign total_ticks   = total_reg;

    // one word in flight: no new input while results are pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input taken while results pending");

    // first byte of a long record carries the length mark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid && bytes_reg == tpre_pkg::LONG_BYTES |-> tape_byte[7])
        else $error("long record without length mark");

    // final byte closes the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid)
        else $error("results continue after last");

    // total only moves when a record is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != tpre_pkg::ST_LOAD |=> $stable(total_ticks))
        else $error("total changed outside record load");

    // status-only result is always a single word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last && tape_byte == 8'h00)
        else $error("malformed status word");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tape pulse record encoder. A behavioral
// model of the rescale, short-signal and record-format rules predicts each
// record word; a clocked driver and monitor move words with random idling,
// a long output stall, and register changes between drained phases.
// ----------------------------------------------------------------------------
module tb;

    localparam logic       OP_DELTA    = 1'b0;
    localparam logic [1:0] STOP_NONE   = 2'd0;
    localparam logic [1:0] STOP_UNUSED = 2'd3;

    localparam logic [63:0] LONG_MAX    = (64'd1 << tpre_pkg::DEF_LONG_BITS) - 64'd1;
    localparam logic [31:0] COUNT_MAX   = 32'hffff_ffff;
    localparam logic [38:0] DELTA_ONES  = {tpre_pkg::DELTA_W{1'b1}};
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          LONG_HOLD   = 400;

    typedef struct packed {
        logic [7:0]  tape_byte;
        logic        byte_valid;
        logic        last;
        logic [31:0] warning_count;
        logic [31:0] error_count;
        logic [63:0] total_ticks;
    } record_word_t;

    typedef struct packed {
        logic        op;
        logic [38:0] delta;
    } pulse_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [tpre_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tpre_pkg::CFG_DAT_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           op = 1'b0;
    logic [tpre_pkg::DELTA_W-1:0]   delta = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [7:0]                     tape_byte;
    logic                           byte_valid;
    logic                           last;
    logic [tpre_pkg::CNT_OUT_W-1:0] warning_count;
    logic [tpre_pkg::CNT_OUT_W-1:0] error_count;
    logic [tpre_pkg::TOTAL_W-1:0]   total_ticks;

    tape_pulse_record_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .delta         (delta),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tape_byte     (tape_byte),
        .byte_valid    (byte_valid),
        .last          (last),
        .warning_count (warning_count),
        .error_count   (error_count),
        .total_ticks   (total_ticks)
    );

    always #5 clk = ~clk;

    // register mirror and encoder state
    logic [7:0]  m_timer = 8'd1;
    logic [7:0]  m_prec = 8'd1;
    logic        m_start_on = 1'b0;
    logic [15:0] m_start_secs = 16'd0;
    logic [1:0]  m_stop_mode = STOP_NONE;
    logic [15:0] m_stop_secs = 16'd1;
    logic        m_first = 1'b1;
    logic [31:0] m_warn = '0;
    logic [31:0] m_err = '0;
    logic [63:0] m_total = '0;

    pulse_t       pulse_q[$];
    record_word_t record_q[$];
    int           pulses_queued = 0;
    int           pulses_taken = 0;
    int           fail_count = 0;
    int           cycles = 0;
    logic         idle_on = 1'b1;
    int           stall_asks = 0;

    function automatic logic [63:0] clamp_long(input logic [63:0] v);
        return (v > LONG_MAX) ? LONG_MAX : v;
    endfunction

    function automatic logic [31:0] bump_count(input logic [31:0] c);
        return (c == COUNT_MAX) ? c : c + 32'd1;
    endfunction

    function automatic logic [63:0] secs_to_ticks(input logic [15:0] secs);
        return clamp_long(64'(secs) * 64'(m_timer) * 64'(tpre_pkg::USEC_PER_SEC));
    endfunction

    function automatic void push_record(input logic [63:0] d);
        record_word_t w;
        int           nbytes;
        m_total = m_total + d;
        nbytes = (d < 64'(tpre_pkg::SHORT_LIMIT)) ? 2 : 5;
        for (int k = 0; k < nbytes; k++)
        begin
            if (nbytes == 2)
                w.tape_byte = 8'(d >> (8 * (1 - k)));
            else if (k == 0)
                w.tape_byte = 8'(d >> 32) | 8'h80;
            else
                w.tape_byte = 8'(d >> (8 * (4 - k)));
            w.byte_valid    = 1'b1;
            w.last          = (k == nbytes - 1);
            w.warning_count = m_warn;
            w.error_count   = m_err;
            w.total_ticks   = m_total;
            record_q.push_back(w);
        end
    endfunction

    function automatic void predict_pulse(input logic op_i, input logic [38:0] d_i);
        logic [63:0]  d;
        logic [63:0]  prec;
        logic [63:0]  warn_lim;
        logic [63:0]  err_lim;
        record_word_t w;
        if (op_i == tpre_pkg::OP_END)
        begin
            m_first = 1'b1;
            if (m_stop_mode == tpre_pkg::STOP_SECONDS && m_stop_secs != 16'd0)
                push_record(secs_to_ticks(m_stop_secs));
            else if (m_stop_mode == tpre_pkg::STOP_MAX)
                push_record(LONG_MAX);
            else
            begin
                w = '0;
                w.last          = 1'b1;
                w.warning_count = m_warn;
                w.error_count   = m_err;
                w.total_ticks   = m_total;
                record_q.push_back(w);
            end
        end
        else
        begin
            d = 64'(d_i);
            if (m_first)
            begin
                // the first pulse of a stream is raw unless the start delay replaces it
                if (m_start_on)
                    d = (m_start_secs == 16'd0)
                        ? 64'(m_timer) * 64'(tpre_pkg::MIN_START_US)
                        : secs_to_ticks(m_start_secs);
                m_first = 1'b0;
            end
            else
            begin
                prec = (m_prec == 8'd0) ? 64'd1 : 64'(m_prec);
                if (prec == 64'd1)
                    d = d * 64'(m_timer);
                else if (prec != 64'(m_timer))
                    d = (d * 64'(m_timer) + prec / 64'd2) / prec;
            end
            d        = clamp_long(d);
            warn_lim = 64'(m_timer) * 64'(tpre_pkg::WARN_US);
            err_lim  = 64'(m_timer) * 64'(tpre_pkg::ERR_US);
            if (d < err_lim)
            begin
                m_err = bump_count(m_err);
                d     = err_lim;
            end
            else if (d < warn_lim)
                m_warn = bump_count(m_warn);
            push_record(d);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // sender: present the next pulse once the current word is taken
    always @(posedge clk or negedge rst_n)
    begin
        logic        nv;
        logic        nop;
        logic [38:0] nd;
        int          send_gap;
        pulse_t      p;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op       <= OP_DELTA;
            delta    <= '0;
            send_gap = 0;
        end
        else
        begin
            nv  = in_valid;
            nop = op;
            nd  = delta;
            if (in_valid && in_ready)
            begin
                predict_pulse(op, delta);
                pulses_taken++;
                nv       = 1'b0;
                send_gap = idle_on ? $urandom_range(0, 16) : 0;
            end
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pulse_q.size() > 0)
                begin
                    p   = pulse_q.pop_front();
                    nv  = 1'b1;
                    nop = p.op;
                    nd  = p.delta;
                end
            end
            in_valid <= nv;
            op       <= nop;
            delta    <= nd;
        end
    end

    // receiver: check each word, then hold off for a random count
    always @(posedge clk or negedge rst_n)
    begin
        record_word_t want;
        int           recv_wait;
        int           hold_left;
        int           stall_seen;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait  = 0;
            hold_left  = 0;
            stall_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (record_q.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual byte %h valid %b last %b",
                             $time, tape_byte, byte_valid, last);
                    fail_count++;
                end
                else
                begin
                    want = record_q.pop_front();
                    check_field("tape_byte", 64'(want.tape_byte), 64'(tape_byte));
                    check_field("byte_valid", 64'(want.byte_valid), 64'(byte_valid));
                    check_field("last", 64'(want.last), 64'(last));
                    check_field("warning_count", 64'(want.warning_count), 64'(warning_count));
                    check_field("error_count", 64'(want.error_count), 64'(error_count));
                    check_field("total_ticks", want.total_ticks, total_ticks);
                end
                recv_wait = idle_on ? $urandom_range(0, 16) : 0;
            end
            if (stall_asks != stall_seen)
            begin
                stall_seen = stall_asks;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic add_pulse(input logic op_i, input logic [38:0] d_i);
        pulse_t p;
        p.op    = op_i;
        p.delta = d_i;
        pulse_q.push_back(p);
        pulses_queued++;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (!(pulses_taken == pulses_queued && record_q.size() == 0));
    endtask

    task automatic cfg_write(input logic [tpre_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            tpre_pkg::CFG_TIMER_MHZ:  m_timer      = val[7:0];
            tpre_pkg::CFG_PRECISION:  m_prec       = val[7:0];
            tpre_pkg::CFG_START_ON:   m_start_on   = val[0];
            tpre_pkg::CFG_START_SECS: m_start_secs = val;
            tpre_pkg::CFG_STOP_MODE:  m_stop_mode  = val[1:0];
            tpre_pkg::CFG_STOP_SECS:  m_stop_secs  = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        logic [7:0] t;
        t = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(1, 255));
        if ($urandom_range(0, 5) == 0)
            t = 8'd1;
        cfg_write(tpre_pkg::CFG_TIMER_MHZ, 16'(t));
        case ($urandom_range(0, 4))
            0: cfg_write(tpre_pkg::CFG_PRECISION, 16'd1);
            1: cfg_write(tpre_pkg::CFG_PRECISION, 16'(t));
            2: cfg_write(tpre_pkg::CFG_PRECISION, 16'd255);
            default: cfg_write(tpre_pkg::CFG_PRECISION, 16'($urandom_range(1, 255)));
        endcase
        cfg_write(tpre_pkg::CFG_START_ON, 16'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
            0: cfg_write(tpre_pkg::CFG_START_SECS, 16'd0);
            1: cfg_write(tpre_pkg::CFG_START_SECS, 16'hffff);
            default: cfg_write(tpre_pkg::CFG_START_SECS, 16'($urandom_range(1, 20)));
        endcase
        cfg_write(tpre_pkg::CFG_STOP_MODE, 16'($urandom_range(0, 2)));
        cfg_write(tpre_pkg::CFG_STOP_SECS,
                  ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 65535))
                                              : 16'($urandom_range(1, 10)));
    endtask

    function automatic logic [38:0] pick_delta();
        logic [63:0] p;
        logic [63:0] t;
        logic [63:0] c;
        p = (m_prec == 8'd0) ? 64'd1 : 64'(m_prec);
        t = (m_timer == 8'd0) ? 64'd1 : 64'(m_timer);
        case ($urandom_range(0, 9))
            0: c = {$urandom, $urandom};
            1: c = 64'(DELTA_ONES);
            2: c = 64'd0;
            // straddle the error and warning limits in capture ticks
            3, 4, 5: c = p * 64'($urandom_range(0, 50)) + 64'($urandom_range(0, 1));
            6, 7: c = 64'($urandom_range(0, 16'hffff));
            8: c = (64'(tpre_pkg::SHORT_LIMIT) * p) / t + 64'($urandom_range(0, 4)) - 64'd2;
            default: c = {$urandom, $urandom} >> $urandom_range(25, 63);
        endcase
        return c[38:0];
    endfunction

    initial
    begin
        int phase;
        int n;
        int slen;
        int rand_pulses;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: raw first pulse, limits, record sizes, status-only end
        add_pulse(OP_DELTA, 39'd0);
        add_pulse(OP_DELTA, 39'd24);
        add_pulse(OP_DELTA, 39'd25);
        add_pulse(OP_DELTA, 39'd39);
        add_pulse(OP_DELTA, 39'd40);
        add_pulse(OP_DELTA, 39'h7fff);
        add_pulse(OP_DELTA, 39'h8000);
        add_pulse(OP_DELTA, DELTA_ONES);
        add_pulse(tpre_pkg::OP_END, DELTA_ONES);
        wait_drained();

        // fastest timer, multiply path, minimum start delay, saturated stop record
        cfg_write(tpre_pkg::CFG_TIMER_MHZ, 16'd255);
        cfg_write(tpre_pkg::CFG_START_ON, 16'd1);
        cfg_write(tpre_pkg::CFG_START_SECS, 16'd0);
        cfg_write(tpre_pkg::CFG_STOP_MODE, 16'(tpre_pkg::STOP_SECONDS));
        cfg_write(tpre_pkg::CFG_STOP_SECS, 16'hffff);
        add_pulse(OP_DELTA, 39'd12345);
        add_pulse(OP_DELTA, DELTA_ONES);
        add_pulse(OP_DELTA, 39'd1);
        add_pulse(tpre_pkg::OP_END, 39'd0);
        wait_drained();

        // equal precision passes through; longest start delay; maximum stop record
        cfg_write(tpre_pkg::CFG_TIMER_MHZ, 16'd16);
        cfg_write(tpre_pkg::CFG_PRECISION, 16'd16);
        cfg_write(tpre_pkg::CFG_START_SECS, 16'hffff);
        cfg_write(tpre_pkg::CFG_STOP_MODE, 16'(tpre_pkg::STOP_MAX));
        cfg_write(tpre_pkg::CFG_STOP_SECS, 16'd1);
        add_pulse(OP_DELTA, 39'd7);
        add_pulse(OP_DELTA, 39'd500);
        add_pulse(OP_DELTA, 39'h55_5555_5555);
        add_pulse(tpre_pkg::OP_END, 39'h2a_aaaa_aaaa);
        wait_drained();

        // divide with rounding
        cfg_write(tpre_pkg::CFG_TIMER_MHZ, 16'd7);
        cfg_write(tpre_pkg::CFG_PRECISION, 16'd255);
        cfg_write(tpre_pkg::CFG_START_ON, 16'd0);
        cfg_write(tpre_pkg::CFG_STOP_MODE, 16'(tpre_pkg::STOP_SECONDS));
        add_pulse(OP_DELTA, 39'd100);
        add_pulse(OP_DELTA, 39'h2a_aaaa_aaaa);
        add_pulse(OP_DELTA, 39'd127);
        add_pulse(tpre_pkg::OP_END, 39'd0);
        wait_drained();

        // wide write drops to a zero timer, zero precision acts as one, unused stop mode
        cfg_write(tpre_pkg::CFG_TIMER_MHZ, 16'h0100);
        cfg_write(tpre_pkg::CFG_PRECISION, 16'd0);
        cfg_write(tpre_pkg::CFG_STOP_MODE, 16'(STOP_UNUSED));
        add_pulse(OP_DELTA, 39'd5);
        add_pulse(OP_DELTA, 39'd1000);
        add_pulse(tpre_pkg::OP_END, 39'd0);
        wait_drained();

        // stop mode with zero seconds gives no record
        cfg_write(tpre_pkg::CFG_STOP_MODE, 16'(tpre_pkg::STOP_SECONDS));
        cfg_write(tpre_pkg::CFG_STOP_SECS, 16'd0);
        add_pulse(tpre_pkg::OP_END, 39'd0);
        wait_drained();

        phase       = 0;
        rand_pulses = 0;
        while (rand_pulses < 75)
        begin
            idle_on <= (phase % 3) != 0;
            random_config();
            if (phase % 4 == 2)
                stall_asks <= stall_asks + 1;
            n = $urandom_range(12, 24);
            while (n > 0)
            begin
                slen = $urandom_range(1, 6);
                for (int j = 0; j < slen; j++)
                    add_pulse(OP_DELTA, pick_delta());
                // mostly close the stream; sometimes run on or end twice
                if ($urandom_range(0, 7) != 0)
                    add_pulse(tpre_pkg::OP_END, pick_delta());
                if ($urandom_range(0, 9) == 0)
                    add_pulse(tpre_pkg::OP_END, pick_delta());
                n           = n - slen - 1;
                rand_pulses = rand_pulses + slen + 1;
            end
            wait_drained();
            phase++;
        end

        repeat (200) @(posedge clk);
        if (fail_count == 0 && record_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tpre_pkg.sv
rtl/tape_pulse_record_encoder.sv
tb/sv/tb.sv
